// ===== hw/rtl/sorted_time_floor_search_unit_macros.svh =====
// Assertion macros for the floor search unit RTL, used by stfs_back.
`ifndef SORTED_TIME_FLOOR_SEARCH_UNIT_MACROS_SVH
`define SORTED_TIME_FLOOR_SEARCH_UNIT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define STFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define STFS_ASSERT_NEVER(lbl, cond, msg) \
	`STFS_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/stfs_pkg.sv =====
// Shared types, sizes and saturating arithmetic for the floor search unit.
`timescale 1ns / 1ps
package stfs_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int TW    = 48;
	localparam int IW    = 10;

	typedef logic signed [TW-1:0] stamp_t;

	localparam stamp_t STAMP_MAX = {1'b0, {(TW-1){1'b1}}};
	localparam stamp_t STAMP_MIN = {1'b1, {(TW-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t            command;
		stamp_t          tval;
		logic [IW-1:0]   idx;
		logic            utc;
	} item_t;

	typedef struct packed {
		logic            valid;
		item_t           item;
	} head_t;

	typedef struct packed {
		logic [IW-1:0]   found;
		stamp_t          rtime;
		logic            span;
		logic            empty;
		logic            aerr;
	} res_t;

	function automatic stamp_t sat_add(input stamp_t a, input stamp_t b);
		logic signed [TW:0] s;
		s = {a[TW-1], a} + {b[TW-1], b};
		if (s[TW] != s[TW-1]) begin
			return s[TW] ? STAMP_MIN : STAMP_MAX;
		end
		return s[TW-1:0];
	endfunction

	function automatic stamp_t sat_sub(input stamp_t a, input stamp_t b);
		logic signed [TW:0] s;
		s = {a[TW-1], a} - {b[TW-1], b};
		if (s[TW] != s[TW-1]) begin
			return s[TW] ? STAMP_MIN : STAMP_MAX;
		end
		return s[TW-1:0];
	endfunction

endpackage

// ===== hw/rtl/sorted_time_floor_search_unit.sv =====
// Top level of the sorted timestamp list with floor index search.
// Clear and append finish in the idle state and read passes through S_READ; find reads
//   the first and then the last stored timestamp and answers a query at or beyond either
//   end from those, else bisects, reading one midpoint per step (S_BIS, then S_CMP).
// The sequencer takes one command at a time; the RAM read port paces find.
// Reset: arst_n clears the entry count, queues and result valid flag at once;
//   the log start offset resets to 0 and stored timestamps stay undefined.
`timescale 1ns / 1ps
module sorted_time_floor_search_unit import stfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// command side
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           command,
	input  logic signed [TW-1:0] time_value,
	input  logic [IW-1:0]        entry_index,
	input  logic                 use_utc,
	// result side
	input  logic                 pop,
	output logic                 empty,
	output logic [IW-1:0]        found_index,
	output logic signed [TW-1:0] read_time,
	output logic                 in_span,
	output logic                 list_empty,
	output logic                 append_error,
	// log start offset register
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic signed [TW-1:0] cfg_data
);

	stamp_t offset_q;
	item_t  in_item;
	head_t  head;
	logic   deq;
	res_t   res;
	logic   res_valid;

	// The offset register is always ready; the user must write it only while idle, as the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid) begin
			offset_q <= cfg_data;
		end
	end

	// Pack the incoming item for the front end.
	assign in_item.command = cmd_t'(command);
	assign in_item.tval    = time_value;
	assign in_item.idx     = entry_index;
	assign in_item.utc     = use_utc;

	// Front end: accept, offset UTC find queries, queue for the sequencer.
	stfs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.offset  (offset_q),
		.head    (head),
		.deq     (deq)
	);

	// Back end: execute commands against the store, hold one result.
	stfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.deq       (deq),
		.offset    (offset_q),
		.res       (res),
		.res_valid (res_valid),
		.pop       (pop)
	);

	// Unpack the waiting result onto the output ports.
	assign empty        = !res_valid;
	assign found_index  = res.found;
	assign read_time    = res.rtime;
	assign in_span      = res.span;
	assign list_empty   = res.empty;
	assign append_error = res.aerr;

endmodule

// ===== hw/rtl/stfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module stfs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/stfs_front.sv =====
// Front end: accept items, apply the query offset, hold them in a two-entry queue.
`timescale 1ns / 1ps
module stfs_front import stfs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  item_t  in_item,
	input  stamp_t offset,
	output head_t  head,
	input  logic   deq
);

	item_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       acc;
	logic       deq_go;
	item_t      adj;

	assign full   = (cnt_q == 2'd2);
	assign acc    = push && !full;
	assign deq_go = deq && (cnt_q != 2'd0);

	// Find queries in UTC are moved onto the log time base here.
	always_comb begin
		adj = in_item;
		if (in_item.command == CMD_FIND && in_item.utc) begin
			adj.tval = sat_sub(in_item.tval, offset);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wp_q] <= adj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wp_q <= !wp_q;
			end
			if (deq_go) begin
				rp_q <= !rp_q;
			end
			if (acc && !deq_go) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!acc && deq_go) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = ent_q[rp_q];

endmodule

// ===== hw/rtl/stfs_back.sv =====
// Back end: command sequencer, timestamp store, entry count and result register.
`timescale 1ns / 1ps
`include "sorted_time_floor_search_unit_macros.svh"
module stfs_back import stfs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  head_t  head,
	output logic   deq,
	input  stamp_t offset,
	output res_t   res,
	output logic   res_valid,
	input  logic   pop
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FIRST = 6'b000010,
		S_LAST  = 6'b000100,
		S_BIS   = 6'b001000,
		S_CMP   = 6'b010000,
		S_READ  = 6'b100000
	} state_t;

	state_t          state_q;
	state_t          state_d;
	item_t           cmd_q;
	logic [CW-1:0]   count_q;
	stamp_t          first_q;
	logic            span_q;
	logic [AW-1:0]   lo_q;
	logic [AW-1:0]   hi_q;
	logic [AW-1:0]   mid_q;
	res_t            res_q;
	logic            res_valid_q;

	logic            res_free;
	logic            produce;
	res_t            res_d;
	logic            we;
	logic [AW-1:0]   raddr;
	logic [TW-1:0]   rdata;
	stamp_t          rstamp;
	logic [AW-1:0]   last_idx;
	logic [AW-1:0]   mid;
	logic            span_now;
	logic            cnt_clr;
	logic            cnt_inc;
	logic            bis_init;
	logic            idx_ok;

	stfs_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (head.item.tval),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rstamp   = $signed(rdata);
	assign res_free = !res_valid_q || pop;
	assign last_idx = AW'(count_q - CW'(1));
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign span_now = (cmd_q.tval >= first_q) && (cmd_q.tval <= rstamp);
	assign idx_ok   = {{CW{1'b0}}, head.item.idx} < {{IW{1'b0}}, count_q};

	always_comb begin
		state_d   = state_q;
		deq       = 1'b0;
		we        = 1'b0;
		raddr     = '0;
		produce   = 1'b0;
		cnt_clr   = 1'b0;
		cnt_inc   = 1'b0;
		bis_init  = 1'b0;
		res_d       = '0;
		res_d.empty = (count_q == '0);
		case (state_q)
			S_IDLE: begin
				if (head.valid && res_free) begin
					deq = 1'b1;
					case (head.item.command)
						CMD_CLEAR: begin
							cnt_clr     = 1'b1;
							produce     = 1'b1;
							res_d.empty = 1'b1;
						end
						CMD_APPEND: begin
							produce = 1'b1;
							if (count_q < CW'(DEPTH)) begin
								we          = 1'b1;
								cnt_inc     = 1'b1;
								res_d.empty = 1'b0;
							end else begin
								res_d.aerr = 1'b1;
							end
						end
						CMD_FIND: begin
							if (count_q == '0) begin
								produce = 1'b1;
							end else begin
								raddr   = '0;
								state_d = S_FIRST;
							end
						end
						default: begin
							if (idx_ok) begin
								raddr   = AW'(head.item.idx);
								state_d = S_READ;
							end else begin
								produce = 1'b1;
							end
						end
					endcase
				end
			end
			S_FIRST: begin
				raddr   = last_idx;
				state_d = S_LAST;
			end
			S_LAST: begin
				if (cmd_q.tval <= first_q) begin
					produce    = 1'b1;
					res_d.span = span_now;
					state_d    = S_IDLE;
				end else if (cmd_q.tval >= rstamp) begin
					produce     = 1'b1;
					res_d.found = IW'(last_idx);
					res_d.span  = span_now;
					state_d     = S_IDLE;
				end else begin
					bis_init = 1'b1;
					state_d  = S_BIS;
				end
			end
			S_BIS: begin
				if ((hi_q - lo_q) <= AW'(1)) begin
					produce     = 1'b1;
					res_d.found = IW'(lo_q);
					res_d.span  = span_q;
					state_d     = S_IDLE;
				end else begin
					raddr   = mid;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = S_BIS;
			end
			S_READ: begin
				produce     = 1'b1;
				res_d.rtime = cmd_q.utc ? sat_add(rstamp, offset) : rstamp;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			cmd_q <= head.item;
		end
		if (state_q == S_FIRST) begin
			first_q <= rstamp;
		end
		if (state_q == S_LAST) begin
			span_q <= span_now;
		end
		if (bis_init) begin
			lo_q <= '0;
			hi_q <= last_idx;
		end else if (state_q == S_CMP) begin
			if (rstamp <= cmd_q.tval) begin
				lo_q <= mid_q;
			end else begin
				hi_q <= mid_q;
			end
		end
		if (state_q == S_BIS) begin
			mid_q <= mid;
		end
		if (produce) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				count_q <= '0;
			end else if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (produce) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	`STFS_ASSERT(a_state_onehot, $onehot(state_q), "sequencer state not one-hot")
	`STFS_ASSERT(a_count_range, count_q <= CW'(DEPTH), "entry count beyond depth")
	`STFS_ASSERT_NEVER(a_busy_result, (state_q != S_IDLE) && res_valid_q,
		"result pending while a command is in flight")
	`STFS_ASSERT(a_bis_order, (state_q == S_BIS) |-> (lo_q < hi_q),
		"bisection bounds crossed")
	`STFS_ASSERT(a_result_hold, (res_valid_q && !pop) |=> (res_valid_q && $stable(res_q)),
		"waiting result lost or changed")

endmodule

// ===== test/tb_sorted_time_floor_search_unit.sv =====
// Self-checking testbench for the sorted timestamp list with floor index search.
`timescale 1ns / 1ps
module tb_sorted_time_floor_search_unit;
	import stfs_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 30;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 450;

	localparam logic signed [TW:0] WIDE_MAX = STAMP_MAX;
	localparam logic signed [TW:0] WIDE_MIN = STAMP_MIN;

	// One row of the directed plan: an offset write or a command item, with an
	// optional hand-written expectation.
	typedef struct {
		bit     is_cfg;
		cmd_t   cmd;
		stamp_t tv;
		int     idx;
		bit     utc;
		bit     typed;
		res_t   want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 push = 1'b0;
	logic                 full;
	logic [1:0]           command = CMD_CLEAR;
	logic signed [TW-1:0] time_value = '0;
	logic [IW-1:0]        entry_index = '0;
	logic                 use_utc = 1'b0;
	logic                 pop = 1'b0;
	logic                 empty;
	logic [IW-1:0]        found_index;
	logic signed [TW-1:0] read_time;
	logic                 in_span;
	logic                 list_empty;
	logic                 append_error;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic signed [TW-1:0] cfg_data = '0;

	// Hand-written expectation that travels with the item on offer.
	bit   pin_typed = 1'b0;
	res_t pin_want = '0;

	// Shadow copy of the list and the offset register.
	stamp_t shadow_times [DEPTH];
	int     shadow_count = 0;
	stamp_t shadow_offset = '0;

	res_t   pending_results [$];
	int     n_sent = 0;
	int     n_done = 0;
	int     n_errors = 0;
	int     n_cfg = 0;
	int     n_refused = 0;
	int     max_fill = 0;
	int     cycles = 0;

	// Receiver controls.
	bit     quiet = 1'b0;
	int     hold_requests = 0;
	int     hold_served = 0;
	int     hold_left = 0;

	// Offset the stimulus believes is active, used to aim UTC queries.
	stamp_t cur_offset = '0;
	// Stimulus-side view of the list, used to aim queries and reads.
	stamp_t built [$];

	sorted_time_floor_search_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.time_value   (time_value),
		.entry_index  (entry_index),
		.use_utc      (use_utc),
		.pop          (pop),
		.empty        (empty),
		.found_index  (found_index),
		.read_time    (read_time),
		.in_span      (in_span),
		.list_empty   (list_empty),
		.append_error (append_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// Clamp a 49-bit sum or difference back into the 48-bit signed range.
	function automatic stamp_t clamp_wide(logic signed [TW:0] w);
		if (w > WIDE_MAX) begin
			return STAMP_MAX;
		end
		if (w < WIDE_MIN) begin
			return STAMP_MIN;
		end
		return w[TW-1:0];
	endfunction

	// Floor index by bisection over the shadow list, clamped at both ends.
	function automatic int floor_of(stamp_t q);
		int lo;
		int hi;
		int mid;
		if (shadow_count == 0) begin
			return 0;
		end
		if (q <= shadow_times[0]) begin
			return 0;
		end
		if (q >= shadow_times[shadow_count-1]) begin
			return shadow_count - 1;
		end
		lo = 0;
		hi = shadow_count - 1;
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			if (shadow_times[mid] <= q) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	// Apply one command to the shadow list and return the response it causes.
	function automatic res_t predict_response(cmd_t c, stamp_t tv, logic [IW-1:0] idx,
			logic utc);
		res_t r;
		logic signed [TW:0] w;
		stamp_t q;
		r = '0;
		case (c)
			CMD_CLEAR: begin
				shadow_count = 0;
			end
			CMD_APPEND: begin
				if (shadow_count < DEPTH) begin
					shadow_times[shadow_count] = tv;
					shadow_count++;
				end else begin
					r.aerr = 1'b1;
				end
			end
			CMD_FIND: begin
				w = tv;
				w = w - shadow_offset;
				q = utc ? clamp_wide(w) : tv;
				r.found = IW'(floor_of(q));
				r.span = shadow_count > 0 && q >= shadow_times[0] &&
					q <= shadow_times[shadow_count-1];
			end
			default: begin
				if (int'(idx) < shadow_count) begin
					w = shadow_times[idx];
					w = w + shadow_offset;
					r.rtime = utc ? clamp_wide(w) : shadow_times[idx];
				end
			end
		endcase
		r.empty = shadow_count == 0;
		return r;
	endfunction

	function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
		end
	endfunction

	// Watch both handshakes: check each popped response against the oldest
	// expectation, then predict for each accepted item and track offset writes.
	always @(posedge clk) begin : scoreboard
		res_t got;
		res_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				shadow_offset = cfg_data;
				n_cfg++;
			end
			if (pop && !empty) begin
				got.found = found_index;
				got.rtime = read_time;
				got.span  = in_span;
				got.empty = list_empty;
				got.aerr  = append_error;
				if (pending_results.size() == 0) begin
					n_errors++;
					$display("%0t: response with nothing expected, got %h", $time, got);
				end else begin
					want = pending_results.pop_front();
					field_check("found_index", 64'(want.found), 64'(got.found));
					field_check("read_time", 64'(want.rtime), 64'(got.rtime));
					field_check("in_span", 64'(want.span), 64'(got.span));
					field_check("list_empty", 64'(want.empty), 64'(got.empty));
					field_check("append_error", 64'(want.aerr), 64'(got.aerr));
				end
				n_done++;
			end
			if (push && !full) begin
				want = predict_response(cmd_t'(command), time_value, entry_index, use_utc);
				if (want.aerr) begin
					n_refused++;
				end
				if (shadow_count > max_fill) begin
					max_fill = shadow_count;
				end
				if (pin_typed) begin
					want = pin_want;
				end
				pending_results.push_back(want);
			end
		end
	end

	// Receiver: pop freely with rare random stalls, hold off for a long
	// stretch on request, and make no random stalls while quiet.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			pop <= quiet || $urandom_range(99) >= 6;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d responses outstanding", $time, n_sent - n_done);
			$display("** sorted_time_floor_search_unit: FAILED **");
			$finish;
		end
	end

	function automatic stamp_t rand_stamp();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TW-1:0];
	endfunction

	function automatic res_t outcome(int f, stamp_t t, bit s, bit e, bit a);
		res_t r;
		r.found = IW'(f);
		r.rtime = t;
		r.span  = s;
		r.empty = e;
		r.aerr  = a;
		return r;
	endfunction

	function automatic plan_row_t op(cmd_t c, stamp_t tv, int idx, bit utc);
		plan_row_t p;
		p.is_cfg = 1'b0;
		p.cmd    = c;
		p.tv     = tv;
		p.idx    = idx;
		p.utc    = utc;
		p.typed  = 1'b0;
		p.want   = '0;
		return p;
	endfunction

	function automatic plan_row_t op_typed(cmd_t c, stamp_t tv, int idx, bit utc, res_t e);
		plan_row_t p;
		p = op(c, tv, idx, utc);
		p.typed = 1'b1;
		p.want  = e;
		return p;
	endfunction

	function automatic plan_row_t cfg_op(stamp_t v);
		plan_row_t p;
		p = op(CMD_CLEAR, v, 0, 1'b0);
		p.is_cfg = 1'b1;
		return p;
	endfunction

	// Offer one item and hold it until accepted. Insert a random gap first
	// unless quiet.
	task automatic send_item(cmd_t c, stamp_t tv, int idx, bit utc, bit typed = 1'b0,
			res_t e = '0);
		if (!quiet && $urandom_range(99) < 6) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push        <= 1'b1;
		command     <= c;
		time_value  <= tv;
		entry_index <= IW'(idx);
		use_utc     <= utc;
		pin_typed   <= typed;
		pin_want    <= e;
		do @(posedge clk); while (full);
		n_sent++;
		case (c)
			CMD_CLEAR: built.delete();
			CMD_APPEND: if (built.size() < DEPTH) built.push_back(tv);
			default: ;
		endcase
	endtask

	// Drop push and wait until every expected response has come back.
	task automatic drain();
		push <= 1'b0;
		while (n_done < n_sent) @(posedge clk);
	endtask

	// Write the offset register while the block is idle.
	task automatic set_offset(stamp_t v);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_offset = v;
	endtask

	// Pick a query aimed at the current list: on an entry, next to one,
	// beyond either end, or anywhere.
	function automatic stamp_t aim_query();
		int k;
		int pick;
		if (built.size() == 0) begin
			return rand_stamp();
		end
		k = $urandom_range(built.size() - 1);
		pick = $urandom_range(99);
		if (pick < 30) begin
			return built[k];
		end else if (pick < 50) begin
			return built[k] - 1;
		end else if (pick < 70) begin
			return built[k] + 1;
		end else if (pick < 80) begin
			return built[0] - stamp_t'($urandom_range(1, 1000000));
		end else if (pick < 90) begin
			return built[built.size()-1] + stamp_t'($urandom_range(0, 1000000));
		end
		return rand_stamp();
	endfunction

	task automatic send_query();
		bit utc;
		stamp_t q;
		utc = $urandom_range(99) < 25;
		q = aim_query();
		// Shift a UTC query by the offset so it lands where aimed.
		if (utc) begin
			q = q + cur_offset;
		end
		send_item(CMD_FIND, q, $urandom_range(1023), utc);
	endtask

	task automatic send_read();
		int idx;
		idx = $urandom_range(99) < 85 ? $urandom_range(built.size() + 2) : $urandom_range(1023);
		if (idx > 1023) begin
			idx = 1023;
		end
		send_item(CMD_READ, rand_stamp(), idx, $urandom_range(99) < 30);
	endtask

	// A well-formed episode: clear, build an ascending list (duplicates
	// allowed), then mix finds, reads and further appends, with the odd
	// out-of-order append.
	task automatic build_and_probe();
		int n;
		int m;
		int pick;
		stamp_t cur;
		send_item(CMD_CLEAR, rand_stamp(), $urandom_range(1023), $urandom_range(1));
		n = $urandom_range(99) < 10 ? $urandom_range(60, 200) : $urandom_range(1, 24);
		cur = rand_stamp() >>> 2;
		repeat (n) begin
			send_item(CMD_APPEND, cur, $urandom_range(1023), $urandom_range(1));
			cur = cur + ($urandom_range(99) < 10 ? 0 : stamp_t'($urandom_range(1, 24'hFFFFFF)));
		end
		m = $urandom_range(4, 20);
		repeat (m) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_query();
			end else if (pick < 85) begin
				send_read();
			end else if (pick < 95) begin
				send_item(CMD_APPEND, cur, $urandom_range(1023), $urandom_range(1));
				cur = cur + stamp_t'($urandom_range(1, 1000));
			end else begin
				send_item(CMD_APPEND, rand_stamp(), $urandom_range(1023), $urandom_range(1));
			end
		end
	endtask

	// Noise: fully random commands, with clears kept rare.
	task automatic send_noise();
		cmd_t c;
		repeat ($urandom_range(3, 10)) begin
			c = cmd_t'($urandom_range(3));
			if (c == CMD_CLEAR && $urandom_range(99) < 70) begin
				c = CMD_FIND;
			end
			send_item(c, rand_stamp(), $urandom_range(1023), $urandom_range(1));
		end
	endtask

	initial begin : stimulus
		plan_row_t plan [$];
		stamp_t offs;
		int episode;
		int random_start;
		int pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list, extremes of the time range, every command,
		// out-of-range reads, saturation in both directions, out-of-order data.
		plan.push_back(op_typed(CMD_READ, '0, 0, 1'b0, outcome(0, '0, 0, 1, 0)));
		plan.push_back(op_typed(CMD_FIND, '0, 0, 1'b0, outcome(0, '0, 0, 1, 0)));
		plan.push_back(op_typed(CMD_CLEAR, STAMP_MAX, 1023, 1'b1, outcome(0, '0, 0, 1, 0)));
		plan.push_back(op_typed(CMD_APPEND, STAMP_MIN, 0, 1'b0, outcome(0, '0, 0, 0, 0)));
		plan.push_back(op_typed(CMD_APPEND, stamp_t'(-65536), 0, 1'b0,
			outcome(0, '0, 0, 0, 0)));
		plan.push_back(op_typed(CMD_APPEND, '0, 0, 1'b0, outcome(0, '0, 0, 0, 0)));
		plan.push_back(op_typed(CMD_APPEND, stamp_t'(6553600), 0, 1'b0,
			outcome(0, '0, 0, 0, 0)));
		plan.push_back(op_typed(CMD_APPEND, STAMP_MAX, 0, 1'b0, outcome(0, '0, 0, 0, 0)));
		plan.push_back(op_typed(CMD_FIND, STAMP_MIN, 0, 1'b0, outcome(0, '0, 1, 0, 0)));
		plan.push_back(op_typed(CMD_FIND, STAMP_MAX, 0, 1'b0, outcome(4, '0, 1, 0, 0)));
		plan.push_back(op(CMD_FIND, stamp_t'(3276800), 0, 1'b0));
		plan.push_back(op(CMD_FIND, '0, 0, 1'b0));
		plan.push_back(op_typed(CMD_READ, '0, 4, 1'b0, outcome(0, STAMP_MAX, 0, 0, 0)));
		plan.push_back(op_typed(CMD_READ, '0, 5, 1'b0, outcome(0, '0, 0, 0, 0)));
		plan.push_back(op_typed(CMD_READ, '0, 1023, 1'b1, outcome(0, '0, 0, 0, 0)));
		plan.push_back(cfg_op(STAMP_MAX));
		plan.push_back(op_typed(CMD_READ, '0, 4, 1'b1, outcome(0, STAMP_MAX, 0, 0, 0)));
		plan.push_back(op(CMD_READ, '0, 2, 1'b1));
		plan.push_back(op(CMD_FIND, STAMP_MIN, 0, 1'b1));
		plan.push_back(cfg_op(STAMP_MIN));
		plan.push_back(op(CMD_FIND, stamp_t'(1), 0, 1'b1));
		plan.push_back(op_typed(CMD_READ, '0, 0, 1'b1, outcome(0, STAMP_MIN, 0, 0, 0)));
		plan.push_back(op(CMD_APPEND, stamp_t'(-5), 0, 1'b0));
		plan.push_back(op(CMD_FIND, '0, 0, 1'b0));
		plan.push_back(op_typed(CMD_CLEAR, '0, 0, 1'b0, outcome(0, '0, 0, 1, 0)));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				set_offset(plan[i].tv);
			end else begin
				send_item(plan[i].cmd, plan[i].tv, plan[i].idx, plan[i].utc, plan[i].typed,
					plan[i].want);
			end
		end

		// Random part: mostly well-formed lists with random content, some noise,
		// offset changes between episodes, one long receiver hold-off, one quiet
		// stretch and one full pause of the sender.
		set_offset('0);
		random_start = n_sent;
		episode = 0;
		while (n_sent - random_start < RANDOM_ITEMS) begin
			quiet = episode >= 8 && episode < 12;
			if (episode == 2) begin
				// Keep offering items while the receiver holds off so the
				// block backs up and stalls its input.
				hold_requests++;
				repeat (60) send_read();
				repeat (20) send_item(CMD_APPEND, rand_stamp(), 0, $urandom_range(1));
			end else if (episode % 6 == 3) begin
				pick = $urandom_range(4);
				case (pick)
					0: offs = '0;
					1: offs = STAMP_MAX;
					2: offs = STAMP_MIN;
					3: offs = stamp_t'($signed($urandom_range(0, 32'hFFFFFFFF)));
					default: offs = rand_stamp();
				endcase
				set_offset(offs);
				build_and_probe();
			end else if (episode == 10) begin
				drain();
				build_and_probe();
			end else if ($urandom_range(99) < 80) begin
				build_and_probe();
			end else begin
				send_noise();
			end
			episode++;
		end
		quiet = 1'b0;

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d commands and %0d responses, %0d offset writes;",
			n_sent, n_done, n_cfg);
		$display("list grew to %0d entries, %0d appends refused on a full list.",
			max_fill, n_refused);
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("** sorted_time_floor_search_unit: PASSED **");
		end else begin
			$display("%0d mismatches, %0d responses missing", n_errors, pending_results.size());
			$display("** sorted_time_floor_search_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/stfs_pkg.sv
hw/rtl/stfs_ram.sv
hw/rtl/stfs_front.sv
hw/rtl/stfs_back.sv
hw/rtl/sorted_time_floor_search_unit.sv
test/tb_sorted_time_floor_search_unit.sv
